// ===== hdl/lap_pkg.sv =====
// Shared types and constants for the lifetime aliasing placer.
// Used by lifetime_aliasing_placer; no dependencies of its own.
package lap_pkg;

  // Sequencer states, one-hot encoded.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_BRD   = 9'b000000010,
    S_BCHK  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_ALIGN = 9'b000010000,
    S_EVAL  = 9'b000100000,
    S_NEW   = 9'b001000000,
    S_PLACE = 9'b010000000,
    S_EMIT  = 9'b100000000
  } lap_state_t;

  // Result status codes.
  localparam logic [2:0] ST_EXISTING   = 3'd0;
  localparam logic [2:0] ST_NEW_BLOCK  = 3'd1;
  localparam logic [2:0] ST_NO_TYPE    = 3'd2;
  localparam logic [2:0] ST_BLOCK_FULL = 3'd3;
  localparam logic [2:0] ST_PLACE_FULL = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEFAULT_SIZE = 2'd0;
  localparam logic [1:0] CFG_GRANULARITY  = 2'd1;
  localparam logic [1:0] CFG_TYPE_COUNT   = 2'd2;
  localparam logic [1:0] CFG_DEVICE_LOCAL = 2'd3;

  localparam int SIZE_W = 40;
  localparam int ALIGN_W = 21;
  localparam int TYPE_W = 32;
  localparam int USE_W = 8;

endpackage

// ===== hdl/lap_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lifetime_aliasing_placer.sv =====
// Lifetime aware first-fit placer: one allocation request per transaction.
// Each conflict-walk step re-scans all placements, so the search is quadratic in their count.
// One request is in flight at a time; the result register lets the next request enter.
// Reset (synchronous, rst_n low) empties both tables, clears peak and sum, loads defaults.
module lifetime_aliasing_placer
  import lap_pkg::*;
#(
  parameter int MAX_PLACED = 64,
  parameter int MAX_BLOCKS = 16,
  parameter int USE_BITS   = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  // Request channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: alloc_size[39:0], alloc_align[60:40], type_bits[92:61],
  //        first_use[100:93], last_use[108:101], zero fill [111:109]
  input  logic [111:0] in_tdata,
  // tuser: batch_start[0]
  input  logic         in_tuser,
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: status[2:0], block_index[6:3], offset[46:7], aliased[47],
  //        peak_used[88:48], sum_bytes[136:89], zero fill [143:137]
  output logic [143:0] out_tdata,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [39:0]  cfg_wdata
);

  localparam int PW = (MAX_PLACED > 1) ? $clog2(MAX_PLACED) : 1;
  localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int PCW = PW + 1;
  localparam int BCW = BW + 1;
  localparam logic [USE_W-1:0] USE_MASK =
    (USE_BITS >= USE_W) ? {USE_W{1'b1}} : USE_W'((1 << USE_BITS) - 1);
  // Placement entry: last, first, block, size, offset from the top down.
  localparam int PE_W = SIZE_W + SIZE_W + BW + USE_W + USE_W;
  localparam int BE_W = SIZE_W + TYPE_W;

  // Configuration registers.
  logic [39:0] dflt_size_r;
  logic [20:0] gran_r;
  logic [5:0]  type_cnt_r;
  logic [31:0] dev_local_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_size_r <= 40'd268435456;
      gran_r      <= 21'd1;
      type_cnt_r  <= 6'd1;
      dev_local_r <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DEFAULT_SIZE: dflt_size_r <= cfg_wdata;
        CFG_GRANULARITY:  gran_r      <= cfg_wdata[20:0];
        CFG_TYPE_COUNT:   type_cnt_r  <= cfg_wdata[5:0];
        CFG_DEVICE_LOCAL: dev_local_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Sequencer and working registers.
  lap_state_t state_r, state_nxt;
  logic [PCW-1:0] place_cnt_r, place_cnt_nxt;
  logic [BCW-1:0] block_cnt_r, block_cnt_nxt;
  logic [40:0] peak_r, peak_nxt;
  logic [47:0] sum_r, sum_nxt;

  logic [39:0] size_r, size_nxt;
  logic [20:0] align_r, align_nxt;
  logic [31:0] tbits_r, tbits_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  last_r, last_nxt;

  logic [BCW-1:0] b_r, b_nxt;
  logic [39:0] bsize_r, bsize_nxt;
  logic        any_r, any_nxt;
  logic [40:0] cand_r, cand_nxt;
  logic [41:0] a_r, a_nxt;

  // Selection walk: each pass finds the next conflict in (offset, index) order.
  logic [PCW-1:0] iss_r, iss_nxt;
  logic        pv_r, pv_nxt;
  logic [PW-1:0] pidx_r, pidx_nxt;
  logic        have_prev_r, have_prev_nxt;
  logic [39:0] prev_off_r, prev_off_nxt;
  logic [PW-1:0] prev_idx_r, prev_idx_nxt;
  logic        have_best_r, have_best_nxt;
  logic [39:0] best_off_r, best_off_nxt;
  logic [39:0] best_size_r, best_size_nxt;
  logic [PW-1:0] best_idx_r, best_idx_nxt;

  // Result of the current request.
  logic [2:0]  res_status_r, res_status_nxt;
  logic [BW-1:0] res_blk_r, res_blk_nxt;
  logic [39:0] res_off_r, res_off_nxt;
  logic        res_alias_r, res_alias_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [143:0] out_data_r, out_data_nxt;

  // Memories.
  logic            pm_we;
  logic [PW-1:0]   pm_waddr;
  logic [PE_W-1:0] pm_wdata;
  logic [PE_W-1:0] pm_rdata;
  logic            bm_we;
  logic [BW-1:0]   bm_waddr;
  logic [BE_W-1:0] bm_wdata;
  logic [BE_W-1:0] bm_rdata;

  lap_ram #(.WIDTH(PE_W), .DEPTH(MAX_PLACED)) u_place_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (iss_r[PW-1:0]),
    .rdata (pm_rdata)
  );

  lap_ram #(.WIDTH(BE_W), .DEPTH(MAX_BLOCKS)) u_block_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (b_r[BW-1:0]),
    .rdata (bm_rdata)
  );

  // Fields of the placement entry being scanned.
  logic [39:0] pe_off, pe_size;
  logic [BW-1:0] pe_blk;
  logic [7:0]  pe_first, pe_last;
  assign pe_off   = pm_rdata[39:0];
  assign pe_size  = pm_rdata[79:40];
  assign pe_blk   = pm_rdata[80 +: BW];
  assign pe_first = pm_rdata[80 + BW +: USE_W];
  assign pe_last  = pm_rdata[88 + BW +: USE_W];

  logic [41:0] am1;
  logic [42:0] a_plus_size;
  logic [40:0] best_end;
  logic [31:0] type_ok;
  logic [4:0]  type_sel;
  logic        type_found;
  logic [39:0] in_size;
  logic [20:0] in_align;
  logic        same_blk, overlap, after_prev, before_best;

  assign in_size     = in_tdata[39:0];
  assign in_align    = in_tdata[60:40];
  assign am1         = 42'(align_r) - 42'd1;
  assign a_plus_size = 43'(a_r) + 43'(size_r);
  assign best_end    = 41'(best_off_r) + 41'(best_size_r);

  assign same_blk    = (pe_blk == b_r[BW-1:0]);
  assign overlap     = !((pe_last < first_r) || (pe_first > last_r));
  assign after_prev  = !have_prev_r || (pe_off > prev_off_r) ||
                       ((pe_off == prev_off_r) && (pidx_r > prev_idx_r));
  assign before_best = !have_best_r || (pe_off < best_off_r) ||
                       ((pe_off == best_off_r) && (pidx_r < best_idx_r));

  // First allowed device-local type below the configured type count.
  always_comb begin
    type_sel   = '0;
    type_found = 1'b0;
    for (int i = 0; i < 32; i++) begin
      type_ok[i] = tbits_r[i] && dev_local_r[i] && (7'(i) < 7'(type_cnt_r));
    end
    for (int i = 31; i >= 0; i--) begin
      if (type_ok[i]) begin
        type_sel   = 5'(i);
        type_found = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    place_cnt_nxt  = place_cnt_r;
    block_cnt_nxt  = block_cnt_r;
    peak_nxt       = peak_r;
    sum_nxt        = sum_r;
    size_nxt       = size_r;
    align_nxt      = align_r;
    tbits_nxt      = tbits_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    b_nxt          = b_r;
    bsize_nxt      = bsize_r;
    any_nxt        = any_r;
    cand_nxt       = cand_r;
    a_nxt          = a_r;
    iss_nxt        = iss_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = pidx_r;
    have_prev_nxt  = have_prev_r;
    prev_off_nxt   = prev_off_r;
    prev_idx_nxt   = prev_idx_r;
    have_best_nxt  = have_best_r;
    best_off_nxt   = best_off_r;
    best_size_nxt  = best_size_r;
    best_idx_nxt   = best_idx_r;
    res_status_nxt = res_status_r;
    res_blk_nxt    = res_blk_r;
    res_off_nxt    = res_off_r;
    res_alias_nxt  = res_alias_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    pm_we          = 1'b0;
    pm_waddr       = place_cnt_r[PW-1:0];
    pm_wdata       = {last_r, first_r, res_blk_r, size_r, res_off_r};
    bm_we          = 1'b0;
    bm_waddr       = block_cnt_r[BW-1:0];
    bm_wdata       = {32'd1 << type_sel, (size_r > dflt_size_r) ? size_r : dflt_size_r};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          // A batch start clears the placement table, peak and sum first.
          logic [PCW-1:0] pc;
          logic [48:0]    s;
          pc = in_tuser ? '0 : place_cnt_r;
          s  = 49'(in_tuser ? 48'd0 : sum_r) + 49'(in_size);
          if (in_tuser) begin
            peak_nxt = '0;
          end
          place_cnt_nxt = pc;
          sum_nxt       = s[48] ? {48{1'b1}} : s[47:0];
          size_nxt      = in_size;
          align_nxt     = (in_align < gran_r) ? gran_r : in_align;
          tbits_nxt     = in_tdata[92:61];
          first_nxt     = in_tdata[100:93] & USE_MASK;
          last_nxt      = in_tdata[108:101] & USE_MASK;
          b_nxt         = '0;
          if (32'(pc) >= 32'(MAX_PLACED)) begin
            res_status_nxt = ST_PLACE_FULL;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_BRD;
          end
        end
      end

      S_BRD: begin
        if (b_r >= block_cnt_r) begin
          state_nxt = S_NEW;
        end else begin
          state_nxt = S_BCHK;
        end
      end

      S_BCHK: begin
        bsize_nxt = bm_rdata[39:0];
        if ((bm_rdata[71:40] & tbits_r) == 32'd0) begin
          b_nxt     = b_r + BCW'(1);
          state_nxt = S_BRD;
        end else begin
          any_nxt       = 1'b0;
          cand_nxt      = '0;
          have_prev_nxt = 1'b0;
          have_best_nxt = 1'b0;
          iss_nxt       = '0;
          state_nxt     = S_SCAN;
        end
      end

      S_SCAN: begin
        if (iss_r < place_cnt_r) begin
          pv_nxt   = 1'b1;
          pidx_nxt = iss_r[PW-1:0];
          iss_nxt  = iss_r + PCW'(1);
        end
        if (pv_r) begin
          if (same_blk) begin
            any_nxt = 1'b1;
          end
          if (same_blk && overlap && after_prev && before_best) begin
            have_best_nxt = 1'b1;
            best_off_nxt  = pe_off;
            best_size_nxt = pe_size;
            best_idx_nxt  = pidx_r;
          end
        end else if (iss_r >= place_cnt_r) begin
          state_nxt = S_ALIGN;
        end
      end

      S_ALIGN: begin
        if (align_r <= 21'd1) begin
          a_nxt = 42'(cand_r);
        end else begin
          a_nxt = (42'(cand_r) + am1) & ~am1;
        end
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        if (have_best_r) begin
          if (a_plus_size <= 43'(best_off_r)) begin
            res_status_nxt = ST_EXISTING;
            res_blk_nxt    = b_r[BW-1:0];
            res_off_nxt    = a_r[39:0];
            res_alias_nxt  = any_r;
            state_nxt      = S_PLACE;
          end else begin
            // Running candidate follows the furthest conflict end so far.
            if (best_end > cand_r) begin
              cand_nxt = best_end;
            end
            have_prev_nxt = 1'b1;
            prev_off_nxt  = best_off_r;
            prev_idx_nxt  = best_idx_r;
            have_best_nxt = 1'b0;
            iss_nxt       = '0;
            state_nxt     = S_SCAN;
          end
        end else if (a_plus_size <= 43'(bsize_r)) begin
          res_status_nxt = ST_EXISTING;
          res_blk_nxt    = b_r[BW-1:0];
          res_off_nxt    = a_r[39:0];
          res_alias_nxt  = any_r;
          state_nxt      = S_PLACE;
        end else begin
          b_nxt     = b_r + BCW'(1);
          state_nxt = S_BRD;
        end
      end

      S_NEW: begin
        if (!type_found) begin
          res_status_nxt = ST_NO_TYPE;
          state_nxt      = S_EMIT;
        end else if (32'(block_cnt_r) >= 32'(MAX_BLOCKS)) begin
          res_status_nxt = ST_BLOCK_FULL;
          state_nxt      = S_EMIT;
        end else begin
          bm_we          = 1'b1;
          block_cnt_nxt  = block_cnt_r + BCW'(1);
          res_status_nxt = ST_NEW_BLOCK;
          res_blk_nxt    = block_cnt_r[BW-1:0];
          res_off_nxt    = '0;
          res_alias_nxt  = 1'b0;
          state_nxt      = S_PLACE;
        end
      end

      S_PLACE: begin
        logic [40:0] endp;
        endp          = 41'(res_off_r) + 41'(size_r);
        pm_we         = 1'b1;
        place_cnt_nxt = place_cnt_r + PCW'(1);
        if (endp > peak_r) begin
          peak_nxt = endp;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          logic ok;
          ok            = (res_status_r == ST_EXISTING) || (res_status_r == ST_NEW_BLOCK);
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, sum_r, peak_r,
                           ok ? res_alias_r : 1'b0,
                           ok ? res_off_r : 40'd0,
                           ok ? 4'(res_blk_r) : 4'd0,
                           res_status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      place_cnt_r <= '0;
      block_cnt_r <= '0;
      peak_r      <= '0;
      sum_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      place_cnt_r <= place_cnt_nxt;
      block_cnt_r <= block_cnt_nxt;
      peak_r      <= peak_nxt;
      sum_r       <= sum_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers need no reset.
  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    align_r      <= align_nxt;
    tbits_r      <= tbits_nxt;
    first_r      <= first_nxt;
    last_r       <= last_nxt;
    b_r          <= b_nxt;
    bsize_r      <= bsize_nxt;
    any_r        <= any_nxt;
    cand_r       <= cand_nxt;
    a_r          <= a_nxt;
    iss_r        <= iss_nxt;
    pidx_r       <= pidx_nxt;
    have_prev_r  <= have_prev_nxt;
    prev_off_r   <= prev_off_nxt;
    prev_idx_r   <= prev_idx_nxt;
    have_best_r  <= have_best_nxt;
    best_off_r   <= best_off_nxt;
    best_size_r  <= best_size_nxt;
    best_idx_r   <= best_idx_nxt;
    res_status_r <= res_status_nxt;
    res_blk_r    <= res_blk_nxt;
    res_off_r    <= res_off_nxt;
    res_alias_r  <= res_alias_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for lifetime_aliasing_placer: streams allocation requests,
// predicts each placement result in a behavioral model and compares every result field.
// Depends on lap_pkg and the lifetime_aliasing_placer RTL only.
`timescale 1ns / 1ps

module testbench;
  import lap_pkg::*;

  localparam int NUM_PLACED = 64;
  localparam int NUM_BLOCKS = 16;
  localparam logic [39:0] MASK40 = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [47:0] sum_bytes;
    logic [40:0] peak_used;
    logic        aliased;
    logic [39:0] offset;
    logic [3:0]  block_index;
    logic [2:0]  status;
  } placement_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [39:0]  cfg_wdata;

  lifetime_aliasing_placer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: placements of the current batch and the persistent block table.
  logic [39:0] pl_offset [NUM_PLACED];
  logic [39:0] pl_size   [NUM_PLACED];
  int          pl_block  [NUM_PLACED];
  logic [7:0]  pl_first  [NUM_PLACED];
  logic [7:0]  pl_last   [NUM_PLACED];
  int          pl_count;
  logic [39:0] blk_size  [NUM_BLOCKS];
  logic [31:0] blk_types [NUM_BLOCKS];
  int          blk_count;
  logic [40:0] batch_peak;
  logic [47:0] batch_sum;

  // Predictor copy of the configuration registers.
  logic [39:0] reg_default_size;
  logic [20:0] reg_granularity;
  logic [5:0]  reg_type_count;
  logic [31:0] reg_device_local;

  placement_t expected_placements[$];
  int mismatch_count;
  int result_count;
  bit out_stall_enable;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A generous ceiling on the whole run, quadratic scans and stalls included.
  initial begin
    #400ms;
    $display("testbench failed");
    $finish;
  end

  function automatic logic [41:0] round_up(logic [41:0] v, logic [41:0] a);
    if (a <= 1) return v;
    return (v + a - 1) & ~(a - 1);
  endfunction

  // Works out the placement of one request and updates the predictor state.
  function automatic placement_t place_request(bit batch_start, logic [39:0] size,
                                               logic [20:0] align_in, logic [31:0] tbits,
                                               logic [7:0] first, logic [7:0] last);
    placement_t  r;
    logic [41:0] align, cand, a, cend;
    int          conflicts[$];
    int          b, i, j, tmp, chosen_type;
    bit          found, fits, any;
    logic [47:0] new_sum;
    r = '0;
    if (batch_start) begin
      pl_count = 0;
      batch_peak = '0;
      batch_sum = '0;
    end
    align = (align_in < reg_granularity) ? reg_granularity : align_in;
    new_sum = batch_sum + size;
    batch_sum = (new_sum < batch_sum) ? MASK48 : new_sum;
    found = 0;
    if (pl_count >= NUM_PLACED) begin
      r.status = ST_PLACE_FULL;
    end else begin
      for (b = 0; b < blk_count && !found; b++) begin
        if ((blk_types[b] & tbits) == 0) continue;
        any = 0;
        conflicts.delete();
        for (i = 0; i < pl_count; i++) begin
          if (pl_block[i] != b) continue;
          any = 1;
          if (!(pl_last[i] < first || pl_first[i] > last)) begin
            // Stable insertion by offset keeps equal offsets in placement order.
            j = conflicts.size();
            conflicts.insert(conflicts.size(), i);
            while (j > 0 && pl_offset[conflicts[j-1]] > pl_offset[i]) begin
              tmp = conflicts[j-1];
              conflicts[j-1] = conflicts[j];
              conflicts[j] = tmp;
              j--;
            end
          end
        end
        cand = 0;
        fits = 0;
        foreach (conflicts[k]) begin
          a = round_up(cand, align);
          cend = pl_offset[conflicts[k]] + pl_size[conflicts[k]];
          if (a + size <= pl_offset[conflicts[k]]) begin
            cand = a;
            fits = 1;
            break;
          end
          if (cend > cand) cand = cend;
        end
        if (!fits) begin
          a = round_up(cand, align);
          if (a + size <= blk_size[b]) begin
            cand = a;
            fits = 1;
          end
        end
        if (fits) begin
          found = 1;
          r.status = ST_EXISTING;
          r.block_index = b[3:0];
          r.offset = cand[39:0];
          r.aliased = any;
        end
      end
      if (!found) begin
        chosen_type = 32;
        for (i = 0; i < ((reg_type_count > 32) ? 32 : reg_type_count); i++) begin
          if (tbits[i] && reg_device_local[i]) begin
            chosen_type = i;
            break;
          end
        end
        if (chosen_type == 32) r.status = ST_NO_TYPE;
        else if (blk_count >= NUM_BLOCKS) r.status = ST_BLOCK_FULL;
        else begin
          blk_size[blk_count] = (size > reg_default_size) ? size : reg_default_size;
          blk_types[blk_count] = 32'd1 << chosen_type;
          r.status = ST_NEW_BLOCK;
          r.block_index = blk_count[3:0];
          r.offset = '0;
          r.aliased = 0;
          blk_count++;
        end
      end
      if (r.status <= ST_NEW_BLOCK) begin
        pl_offset[pl_count] = r.offset;
        pl_size[pl_count] = size;
        pl_block[pl_count] = r.block_index;
        pl_first[pl_count] = first;
        pl_last[pl_count] = last;
        pl_count++;
        if ({1'b0, r.offset} + size > batch_peak) batch_peak = {1'b0, r.offset} + size;
      end
    end
    r.peak_used = batch_peak;
    r.sum_bytes = batch_sum;
    return r;
  endfunction

  // Result checker: if out_stall_enable is set, the receiver stalls randomly before each transaction.
  initial begin
    placement_t got, want;
    int stall;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = out_stall_enable ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
      got = out_tdata[136:0];
      result_count++;
      if (expected_placements.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transaction %h", got);
      end else begin
        want = expected_placements.pop_front();
        if (got.status !== want.status || got.block_index !== want.block_index ||
            got.offset !== want.offset || got.aliased !== want.aliased ||
            got.peak_used !== want.peak_used || got.sum_bytes !== want.sum_bytes ||
            out_tdata[143:137] !== 7'd0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d mismatch: expected st=%0d blk=%0d off=%h al=%0d pk=%h sum=%h,",
                     result_count, want.status, want.block_index, want.offset, want.aliased,
                     want.peak_used, want.sum_bytes,
                     " got st=%0d blk=%0d off=%h al=%0d pk=%h sum=%h",
                     got.status, got.block_index, got.offset, got.aliased,
                     got.peak_used, got.sum_bytes);
        end
      end
    end
  end

  bit sender_gaps;

  // Sends one request transaction and queues its predicted placement. Valid stays high
  // after the accept so that a following request can go out back to back.
  task automatic send_request(bit batch_start, logic [39:0] size, logic [20:0] align,
                              logic [31:0] tbits, logic [7:0] first, logic [7:0] last);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= batch_start;
    in_tdata <= {3'b0, last, first, tbits, align, size};
    @(posedge clk iff in_tready);
    expected_placements.insert(expected_placements.size(),
                               place_request(batch_start, size, align, tbits, first, last));
  endtask

  // Waits until every result is back, then lets the block settle before a register write.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [39:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      CFG_DEFAULT_SIZE: reg_default_size = value;
      CFG_GRANULARITY:  reg_granularity = value[20:0];
      CFG_TYPE_COUNT:   reg_type_count = value[5:0];
      default:          reg_device_local = value[31:0];
    endcase
  endtask

  // Directed requests: field extremes, aliasing by disjoint lifetimes, every status but ST_PLACE_FULL.
  task automatic test_directed();
    write_register(CFG_DEFAULT_SIZE, 40'd4096);
    write_register(CFG_TYPE_COUNT, 40'd32);
    write_register(CFG_DEVICE_LOCAL, 40'hFFFF_FFFF);
    send_request(1, 40'd1000, 21'd1, 32'h1, 8'd0, 8'd3);
    send_request(0, 40'd1000, 21'd256, 32'h1, 8'd4, 8'd9);   // disjoint lifetime aliases
    send_request(0, 40'd500, 21'd64, 32'h1, 8'd2, 8'd5);     // overlaps both
    send_request(0, 40'd0, 21'd1, 32'h1, 8'd0, 8'd255);      // zero size
    send_request(0, 40'd10, 21'd1, 32'h1, 8'd9, 8'd2);       // inverted lifetime
    send_request(0, 40'd100, 21'd1048576, 32'h1, 8'd0, 8'd0);// largest power-of-two alignment
    send_request(0, MASK40, 21'd1, 32'h8000_0000, 8'd255, 8'd255); // largest size
    send_request(0, 40'd16, 21'd0, 32'h0, 8'd0, 8'd1);       // no matching type
    send_request(0, MASK40, 21'd1, 32'h8000_0000, 8'd1, 8'd1); // largest size, aliased in the same block
    send_request(1, 40'd64, 21'd3, 32'h2, 8'd0, 8'd1);       // non power of two align
    send_request(0, 40'd4096, 21'd1, 32'hAAAA_AAAA, 8'd0, 8'd1);
    wait_drained();
    write_register(CFG_DEVICE_LOCAL, 40'h0);
    send_request(0, 40'd8, 21'd1, 32'hFFFF_FFFF, 8'd0, 8'd0);
    wait_drained();
    write_register(CFG_DEVICE_LOCAL, 40'hFFFF_FFFF);
    write_register(CFG_TYPE_COUNT, 40'd63);                  // counts above 32 clamp
    // Fill the block table with huge requests so the last of them report it full.
    for (int i = 0; i < 14; i++)
      send_request(0, MASK40 - i, 21'd1, 32'h1 << i, 8'd0, 8'd255);
  endtask

  // Fills the placement table past its capacity within one batch.
  task automatic test_placement_full();
    wait_drained();
    write_register(CFG_GRANULARITY, 40'd1048576);
    for (int i = 0; i < NUM_PLACED + 3; i++)
      send_request(i == 0, 40'($urandom_range(1, 5000)), 21'd1, 32'h1,
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Random batches of well-formed requests with random content and occasional noise.
  task automatic test_random(int items, logic [20:0] gran, logic [5:0] types);
    logic [7:0] f, l;
    logic [39:0] sz;
    wait_drained();
    write_register(CFG_GRANULARITY, 40'(gran));
    write_register(CFG_TYPE_COUNT, 40'(types));
    write_register(CFG_DEVICE_LOCAL, 40'($urandom()));
    write_register(CFG_DEFAULT_SIZE, 40'($urandom_range(1, 1 << 20)));
    for (int i = 0; i < items; i++) begin
      f = 8'($urandom_range(0, 255));
      l = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'(f + $urandom_range(0, 30));
      sz = ($urandom_range(0, 15) == 0) ? {$urandom(), 8'($urandom())} :
           40'($urandom_range(0, 300000));
      send_request($urandom_range(0, 11) == 0, sz, 21'd1 << $urandom_range(0, 20),
                   ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(1, 15)),
                   f, l);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_DEFAULT_SIZE;
    cfg_wdata <= '0;
    mismatch_count = 0;
    result_count = 0;
    out_stall_enable = 1;
    sender_gaps = 1;
    reg_default_size = 40'd268435456;
    reg_granularity = 21'd1;
    reg_type_count = 6'd1;
    reg_device_local = 32'd1;
    pl_count = 0;
    blk_count = 0;
    batch_peak = '0;
    batch_sum = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_placement_full();
    // Blocks persist, so the block table is full for the rest of the run; the
    // random phases exercise aliasing within the existing blocks and full-table misses.
    test_random(16, 21'd1, 6'd1);
    out_stall_enable = 0;
    sender_gaps = 0;
    test_random(16, 21'd16, 6'd32);
    out_stall_enable = 1;
    sender_gaps = 1;
    test_random(16, 21'd1048576, 6'd8);

    wait_drained();
    repeat (5000) @(posedge clk);
    if (mismatch_count == 0 && expected_placements.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
